FILE: rtl/core/qrs_pkg.sv
// Package with widths, payload types, status codes and helpers for the quadratic root solver.
`default_nettype none
package qrs_pkg;

  localparam int COEF_W = 16;
  localparam int FRAC_W = 16;
  localparam int OUT_W  = 32;
  localparam int DISC_W = 2 * COEF_W + 1;
  localparam int SQ_N   = COEF_W + FRAC_W + 1;
  localparam int RAD_W  = 2 * SQ_N;
  localparam int REM_W  = SQ_N + 3;
  localparam int NUM_W  = SQ_N + 1;
  localparam int DEN_W  = COEF_W + 1;
  localparam int NB_W   = COEF_W + FRAC_W + 1;
  localparam int CL_W   = NUM_W + 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_AZERO = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic                    a_zero;
    logic                    neg;
    logic                    a_neg;
    logic signed [NB_W-1:0]  nb;
    logic [DEN_W-1:0]        den;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [SQ_N-1:0]  root;
    side_t            side;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] n1;
    logic [DEN_W-1:0] r1;
    logic [NUM_W-1:0] n2;
    logic [DEN_W-1:0] r2;
    logic [DEN_W-1:0] den;
    logic             a_zero;
    logic             neg;
    logic             q1_neg;
    logic             q2_neg;
  } dv_t;

  typedef struct packed {
    logic                    sat;
    logic signed [OUT_W-1:0] val;
  } clamp_t;

  function automatic clamp_t clamp_out(input logic signed [CL_W-1:0] v);
    clamp_t r;
    logic signed [CL_W-1:0] hi;
    logic signed [CL_W-1:0] lo;
    hi = CL_W'(signed'({1'b0, {(OUT_W-1){1'b1}}}));
    lo = -hi - CL_W'(1);
    r.sat = 1'b0;
    r.val = v[OUT_W-1:0];
    if (v > hi) begin
      r.sat = 1'b1;
      r.val = hi[OUT_W-1:0];
    end else if (v < lo) begin
      r.sat = 1'b1;
      r.val = lo[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/quadratic_root_solver.sv
// Top level of the pipelined quadratic root solver.
`default_nettype none
// Each request carries the three Q8.8 coefficients of one quadratic and yields one result
// with both roots in Q16.16, an is_complex flag and a status (ok, leading coefficient zero,
// or saturated). The pipeline accepts a new request every cycle while it is not stalled.
// The products are registered, then the discriminant is formed and registered, a chain of 33
// cells computes the square root one bit per cell, a register forms the numerators, a chain
// of 34 cells divides both numerators by 2a one quotient bit per cell, and the output
// register applies signs and saturation. The whole pipeline stalls only while a finished
// result waits at the output.
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [COEF_W-1:0] in_coef_a,
  input  wire logic signed [COEF_W-1:0] in_coef_b,
  input  wire logic signed [COEF_W-1:0] in_coef_c,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OUT_W-1:0]       out_root_plus_real,
  output logic signed [OUT_W-1:0]       out_root_minus_real,
  output logic signed [OUT_W-1:0]       out_root_plus_imag,
  output logic signed [OUT_W-1:0]       out_root_minus_imag,
  output logic                          out_is_complex,
  output logic [1:0]                    out_status
);

  logic en;

  logic                     p1_v_r;
  logic [2*COEF_W-1:0]      ac_r;
  logic [2*COEF_W-1:0]      bb_r;
  logic                     sdiff_r;
  logic signed [COEF_W-1:0] a_r;
  logic signed [COEF_W-1:0] b_r;

  logic [COEF_W-1:0] am;
  logic [COEF_W-1:0] bm;
  logic [COEF_W-1:0] cm;

  logic [DISC_W-1:0] four_ac;
  logic [DISC_W-1:0] bb_x;
  logic [DISC_W-1:0] disc;
  logic              neg;
  sq_t               sq0_nxt;

  sq_t  sq_d [SQ_N+1];
  logic sq_v [SQ_N+1];
  dv_t  dv_d [NUM_W+1];
  logic dv_v [NUM_W+1];

  logic signed [NUM_W:0]   nbx;
  logic signed [NUM_W:0]   sx;
  logic signed [NUM_W:0]   n1;
  logic signed [NUM_W:0]   n2;
  dv_t                     dv0_nxt;

  logic signed [CL_W-1:0]  q1s;
  logic signed [CL_W-1:0]  q2s;
  clamp_t                  c_pr;
  clamp_t                  c_mr;
  clamp_t                  c_pi;
  clamp_t                  c_mi;
  dv_t                     dl;

  logic                    out_v_r;
  logic signed [OUT_W-1:0] pr_r;
  logic signed [OUT_W-1:0] mr_r;
  logic signed [OUT_W-1:0] pi_r;
  logic signed [OUT_W-1:0] mi_r;
  logic                    cplx_r;
  status_t                 st_r;
  logic signed [OUT_W-1:0] pr_nxt;
  logic signed [OUT_W-1:0] mr_nxt;
  logic signed [OUT_W-1:0] pi_nxt;
  logic signed [OUT_W-1:0] mi_nxt;
  logic                    cplx_nxt;
  status_t                 st_nxt;

  assign en       = !out_v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    am = in_coef_a[COEF_W-1] ? COEF_W'(-in_coef_a) : in_coef_a;
    bm = in_coef_b[COEF_W-1] ? COEF_W'(-in_coef_b) : in_coef_b;
    cm = in_coef_c[COEF_W-1] ? COEF_W'(-in_coef_c) : in_coef_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_valid;
    end
    if (en) begin
      ac_r    <= am * cm;
      bb_r    <= bm * bm;
      sdiff_r <= in_coef_a[COEF_W-1] ^ in_coef_c[COEF_W-1];
      a_r     <= in_coef_a;
      b_r     <= in_coef_b;
    end
  end

  always_comb begin
    four_ac = {ac_r[2*COEF_W-2:0], 2'b00};
    bb_x    = DISC_W'(bb_r);
    neg     = 1'b0;
    if (sdiff_r && (ac_r != '0)) begin
      disc = bb_x + four_ac;
    end else if (bb_x >= four_ac) begin
      disc = bb_x - four_ac;
    end else begin
      disc = four_ac - bb_x;
      neg  = 1'b1;
    end
    sq0_nxt.rad         = RAD_W'({disc, {(2*FRAC_W){1'b0}}});
    sq0_nxt.rem         = '0;
    sq0_nxt.root        = '0;
    sq0_nxt.side.a_zero = a_r == '0;
    sq0_nxt.side.neg    = neg;
    sq0_nxt.side.a_neg  = a_r[COEF_W-1];
    sq0_nxt.side.nb     = -NB_W'(signed'({b_r, {FRAC_W{1'b0}}}));
    sq0_nxt.side.den    = a_r[COEF_W-1] ? DEN_W'(-{a_r[COEF_W-1], a_r} <<< 1)
                                        : DEN_W'({a_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= p1_v_r;
    end
    if (en) begin
      sq_d[0] <= sq0_nxt;
    end
  end

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (sq_v[i]),
      .in_d    (sq_d[i]),
      .out_v_r (sq_v[i+1]),
      .out_d_r (sq_d[i+1])
    );
  end

  always_comb begin
    nbx = (NUM_W+1)'(sq_d[SQ_N].side.nb);
    sx  = signed'({1'b0, sq_d[SQ_N].root});
    if (sq_d[SQ_N].side.neg) begin
      n1 = nbx;
      n2 = sx;
    end else begin
      n1 = nbx + sx;
      n2 = nbx - sx;
    end
    dv0_nxt.n1     = n1[NUM_W] ? NUM_W'(-n1) : n1[NUM_W-1:0];
    dv0_nxt.n2     = n2[NUM_W] ? NUM_W'(-n2) : n2[NUM_W-1:0];
    dv0_nxt.r1     = '0;
    dv0_nxt.r2     = '0;
    dv0_nxt.den    = sq_d[SQ_N].side.den;
    dv0_nxt.a_zero = sq_d[SQ_N].side.a_zero;
    dv0_nxt.neg    = sq_d[SQ_N].side.neg;
    dv0_nxt.q1_neg = n1[NUM_W] ^ sq_d[SQ_N].side.a_neg;
    dv0_nxt.q2_neg = n2[NUM_W] ^ sq_d[SQ_N].side.a_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sq_v[SQ_N];
    end
    if (en) begin
      dv_d[0] <= dv0_nxt;
    end
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (dv_v[j]),
      .in_d    (dv_d[j]),
      .out_v_r (dv_v[j+1]),
      .out_d_r (dv_d[j+1])
    );
  end

  always_comb begin
    dl  = dv_d[NUM_W];
    q1s = dl.q1_neg ? -CL_W'(dl.n1) : CL_W'(dl.n1);
    q2s = dl.q2_neg ? -CL_W'(dl.n2) : CL_W'(dl.n2);
    c_pr = clamp_out(q1s);
    c_mr = clamp_out(dl.neg ? q1s : q2s);
    c_pi = clamp_out(dl.neg ? q2s : '0);
    c_mi = clamp_out(dl.neg ? -q2s : '0);
    if (dl.a_zero) begin
      pr_nxt   = '0;
      mr_nxt   = '0;
      pi_nxt   = '0;
      mi_nxt   = '0;
      cplx_nxt = 1'b0;
      st_nxt   = ST_AZERO;
    end else begin
      pr_nxt   = c_pr.val;
      mr_nxt   = c_mr.val;
      pi_nxt   = c_pi.val;
      mi_nxt   = c_mi.val;
      cplx_nxt = dl.neg;
      st_nxt   = (c_pr.sat || c_mr.sat || c_pi.sat || c_mi.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NUM_W];
    end
    if (en) begin
      pr_r   <= pr_nxt;
      mr_r   <= mr_nxt;
      pi_r   <= pi_nxt;
      mi_r   <= mi_nxt;
      cplx_r <= cplx_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_root_plus_real  = pr_r;
  assign out_root_minus_real = mr_r;
  assign out_root_plus_imag  = pi_r;
  assign out_root_minus_imag = mi_r;
  assign out_is_complex      = cplx_r;
  assign out_status          = st_r;

  a_azero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_AZERO) |->
      (out_root_plus_real == '0) && (out_root_minus_real == '0) &&
      (out_root_plus_imag == '0) && (out_root_minus_imag == '0) && !out_is_complex)
    else $error("Zero leading coefficient result is not cleared.");

  a_real_no_imag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_complex |->
      (out_root_plus_imag == '0) && (out_root_minus_imag == '0))
    else $error("Real roots carry an imaginary part.");

  a_conj_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_complex && (out_status == ST_OK) |->
      (out_root_plus_real == out_root_minus_real) &&
      (out_root_plus_imag == -out_root_minus_imag))
    else $error("Complex roots are not a conjugate pair.");

  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("Result valid right after reset.");

endmodule
`default_nettype wire

FILE: rtl/core/qrs_sqrt_cell.sv
// One digit-by-digit square root cell that retires one root bit per stage.
`default_nettype none
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_v,
  input  wire sq_t  in_d,
  output logic      out_v_r,
  output sq_t       out_d_r
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  sq_t              d_nxt;

  always_comb begin
    rem_sh = {in_d.rem[REM_W-3:0], in_d.rad[RAD_W-1 -: 2]};
    trial  = REM_W'({in_d.root, 2'b01});
    ge     = rem_sh >= trial;
    d_nxt      = in_d;
    d_nxt.rad  = {in_d.rad[RAD_W-3:0], 2'b00};
    d_nxt.rem  = ge ? rem_sh - trial : rem_sh;
    d_nxt.root = {in_d.root[SQ_N-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
    if (en) begin
      out_d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/qrs_div_cell.sv
// One restoring division cell that retires one quotient bit of both lanes per stage.
`default_nettype none
module qrs_div_cell
  import qrs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_v,
  input  wire dv_t  in_d,
  output logic      out_v_r,
  output dv_t       out_d_r
);

  logic [DEN_W:0] t1;
  logic [DEN_W:0] t2;
  logic [DEN_W:0] dd;
  logic [DEN_W:0] s1;
  logic [DEN_W:0] s2;
  logic           g1;
  logic           g2;
  dv_t            d_nxt;

  always_comb begin
    dd = {1'b0, in_d.den};
    t1 = {in_d.r1, in_d.n1[NUM_W-1]};
    t2 = {in_d.r2, in_d.n2[NUM_W-1]};
    g1 = t1 >= dd;
    g2 = t2 >= dd;
    s1 = t1 - dd;
    s2 = t2 - dd;
    d_nxt    = in_d;
    d_nxt.r1 = g1 ? s1[DEN_W-1:0] : t1[DEN_W-1:0];
    d_nxt.r2 = g2 ? s2[DEN_W-1:0] : t2[DEN_W-1:0];
    d_nxt.n1 = {in_d.n1[NUM_W-2:0], g1};
    d_nxt.n2 = {in_d.n2[NUM_W-2:0], g2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
    if (en) begin
      out_d_r <= d_nxt;
    end
  end

endmodule
`default_nettype wire
